// File: sv/obsnf_pkg.sv
package obsnf_pkg;

  localparam int POS_W         = 11;
  localparam int OP_W          = 2;
  localparam int WORD_BITS     = 64;
  localparam int OFF_W         = 6;
  localparam int MAX_POSITIONS = 1024;

  localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;  // unused code, acts as a query

  typedef struct packed {
    logic clr;         // zero the word at the sweep counter, advance
    logic load;        // capture the input transfer
    logic rd_pivot;    // read the word holding the pivot
    logic wr_pivot;    // write back the updated pivot word
    logic scan_start;  // clear the running results
    logic scan_rd;     // read the word at the sweep counter, advance
    logic out_load;    // load the result register
  } obsnf_cmd_t;

  typedef struct packed {
    logic cnt_last;    // sweep counter sits on the last word
    logic out_busy;    // result register holds a result that is not taken this cycle
  } obsnf_status_t;

endpackage

// File: sv/obsnf_ctrl.sv
module obsnf_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  obsnf_pkg::obsnf_status_t status_i,
  output obsnf_pkg::obsnf_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_WR    = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_pivot = 1'b1;
        state_d        = S_WR;
      end
      S_WR: begin
        cmd_o.wr_pivot   = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.cnt_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free or being taken
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/obsnf_datapath.sv
module obsnf_datapath #(
  parameter int MAX_POSITIONS = obsnf_pkg::MAX_POSITIONS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  obsnf_pkg::obsnf_cmd_t        cmd_i,
  output obsnf_pkg::obsnf_status_t     status_o,
  input  logic [obsnf_pkg::OP_W-1:0]   op_i,
  input  logic [obsnf_pkg::POS_W-1:0]  position_i,
  input  logic                         cfg_valid_i,
  input  logic [obsnf_pkg::POS_W-1:0]  cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [obsnf_pkg::POS_W-1:0]  next_above_o,
  output logic [obsnf_pkg::POS_W-1:0]  prev_below_o,
  output logic [obsnf_pkg::POS_W-1:0]  smallest_o,
  output logic [obsnf_pkg::POS_W-1:0]  largest_o,
  output logic                         is_empty_o,
  output logic                         out_of_range_o
);

  localparam int POS_W   = obsnf_pkg::POS_W;
  localparam int OFF_W   = obsnf_pkg::OFF_W;
  localparam int WB      = obsnf_pkg::WORD_BITS;
  localparam int NWORDS  = (MAX_POSITIONS + WB - 1) / WB;
  localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int IDX_W   = WADDR_W + OFF_W;
  localparam int PW      = IDX_W + 1;
  localparam int CW      = ((PW > POS_W) ? PW : POS_W) + 1;

  function automatic logic [OFF_W-1:0] low_bit(logic [WB-1:0] x);
    logic [OFF_W-1:0] r;
    r = OFF_W'(WB - 1);
    for (int i = WB - 1; i >= 0; i--) begin
      if (x[i]) r = OFF_W'(i);
    end
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] high_bit(logic [WB-1:0] x);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = 0; i < WB; i++) begin
      if (x[i]) r = OFF_W'(i);
    end
    return r;
  endfunction

  logic [WB-1:0]        mem [NWORDS];
  logic [POS_W-1:0]     size_q;
  logic [obsnf_pkg::OP_W-1:0] op_q;
  logic [POS_W-1:0]     pos_q;
  logic                 oor_q, upd_q;
  logic [WADDR_W-1:0]   cnt_q;
  logic [WB-1:0]        rd_data_q;
  logic [WADDR_W-1:0]   rd_idx_q;
  logic                 rd_vld_q;
  logic [PW-1:0]        above_q, below_q, lo_q, hi_q;
  logic                 out_valid_q;

  logic                 cnt_last, in_oor, in_upd;
  logic [POS_W-1:0]     pidx;
  logic [WADDR_W-1:0]   pivot_w, rd_addr;
  logic [WB-1:0]        pbit, new_word, amask, bmask, am, bm;
  logic [CW-1:0]        base, posx, idxx, dpos, didx;
  logic [PW-1:0]        wbase;

  assign cnt_last = (cnt_q == WADDR_W'(NWORDS - 1));
  assign status_o.cnt_last = cnt_last;
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign in_oor = (position_i == '0) || (position_i > size_q) ||
                  (32'(position_i) > MAX_POSITIONS);
  assign in_upd = !in_oor && ((op_i == obsnf_pkg::OP_INSERT) ||
                              (op_i == obsnf_pkg::OP_REMOVE));

  assign pidx     = pos_q - POS_W'(1);
  assign pivot_w  = WADDR_W'(pidx >> OFF_W);
  assign pbit     = WB'(1) << pidx[OFF_W-1:0];
  assign new_word = (op_q == obsnf_pkg::OP_INSERT) ? (rd_data_q | pbit) : (rd_data_q & ~pbit);
  assign rd_addr  = cmd_i.rd_pivot ? pivot_w : cnt_q;

  // masks of the scanned word: bits above the pivot, bits below it
  assign base  = CW'(rd_idx_q) << OFF_W;
  assign posx  = CW'(pos_q);
  assign idxx  = posx - CW'(1);
  assign dpos  = posx - base;
  assign didx  = idxx - base;
  assign wbase = PW'(rd_idx_q) << OFF_W;

  always_comb begin
    if (posx <= base) amask = '1;
    else if (posx >= base + CW'(WB)) amask = '0;
    else amask = '1 << dpos[OFF_W-1:0];
    if (idxx >= base + CW'(WB)) bmask = '1;
    else if (idxx <= base) bmask = '0;
    else bmask = (WB'(1) << didx[OFF_W-1:0]) - WB'(1);
  end

  assign am = rd_data_q & amask;
  assign bm = rd_data_q & bmask;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem[cnt_q] <= '0;
    end else if (cmd_i.wr_pivot && upd_q) begin
      mem[pivot_w] <= new_word;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      pos_q <= position_i;
      oor_q <= in_oor;
      upd_q <= in_upd;
    end
    if (cmd_i.scan_rd) rd_idx_q <= cnt_q;
    if (cmd_i.scan_start) begin
      above_q <= '0;
      below_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else if (rd_vld_q) begin
      if ((lo_q == '0) && (rd_data_q != '0)) lo_q <= wbase + PW'(low_bit(rd_data_q)) + PW'(1);
      if (rd_data_q != '0) hi_q <= wbase + PW'(high_bit(rd_data_q)) + PW'(1);
      if ((above_q == '0) && (am != '0)) above_q <= wbase + PW'(low_bit(am)) + PW'(1);
      if (bm != '0) below_q <= wbase + PW'(high_bit(bm)) + PW'(1);
    end
    if (cmd_i.out_load) begin
      next_above_o   <= oor_q ? '0 : POS_W'(above_q);
      prev_below_o   <= oor_q ? '0 : POS_W'(below_q);
      smallest_o     <= POS_W'(lo_q);
      largest_o      <= POS_W'(hi_q);
      is_empty_o     <= (lo_q == '0);
      out_of_range_o <= oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= obsnf_pkg::SIZE_RESET;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) size_q <= cfg_data_i;
      if (cmd_i.clr || cmd_i.scan_rd) cnt_q <= cnt_last ? '0 : cnt_q + WADDR_W'(1);
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/ordered_bitmap_set_neighbour_find_top.sv
// Each accepted transfer is finished before the next is taken: the sweep reads
// the NWORDS bitmap words (NWORDS = MAX_POSITIONS / 64, rounded up) one at a time,
// and a stalled result holds the controller in its last state with the input stalled.
// Reset: asynchronous, active low; afterwards a clearing pass over every word
// zeroes the bitmap while the input is stalled; config writes are taken always.
module ordered_bitmap_set_neighbour_find_top #(
  parameter int MAX_POSITIONS = obsnf_pkg::MAX_POSITIONS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [obsnf_pkg::OP_W-1:0]   op_i,
  input  logic [obsnf_pkg::POS_W-1:0]  position_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [obsnf_pkg::POS_W-1:0]  cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [obsnf_pkg::POS_W-1:0]  next_above_o,
  output logic [obsnf_pkg::POS_W-1:0]  prev_below_o,
  output logic [obsnf_pkg::POS_W-1:0]  smallest_o,
  output logic [obsnf_pkg::POS_W-1:0]  largest_o,
  output logic                         is_empty_o,
  output logic                         out_of_range_o
);

  obsnf_pkg::obsnf_cmd_t    cmd;
  obsnf_pkg::obsnf_status_t status;

  // The size register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequence each item: read the pivot word, write it back updated (in-range updates
  // only), sweep every word in order for neighbours and extremes, load the result.
  obsnf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the bitmap memory, the size register, the sweep and the result register.
  obsnf_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (op_i),
    .position_i     (position_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .next_above_o   (next_above_o),
    .prev_below_o   (prev_below_o),
    .smallest_o     (smallest_o),
    .largest_o      (largest_o),
    .is_empty_o     (is_empty_o),
    .out_of_range_o (out_of_range_o)
  );

  // After an input transfer the input stalls until that item is done.
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  a_empty_extremes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (smallest_o == '0 && largest_o == '0))
    else $error("empty set reports extremes");

  a_oor_neighbours: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (next_above_o == '0 && prev_below_o == '0))
    else $error("ignored position reports neighbours");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_empty_o) |-> (smallest_o <= largest_o && smallest_o != '0))
    else $error("smallest above largest");

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W = obsnf_pkg::POS_W;
  localparam int OP_W = obsnf_pkg::OP_W;
  localparam int MAX_POS = obsnf_pkg::MAX_POSITIONS;
  localparam int NWORDS = MAX_POS / obsnf_pkg::WORD_BITS;
  localparam int LATENCY = NWORDS + 5;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
  } set_req_t;

  typedef struct packed {
    logic [POS_W-1:0] next_above;
    logic [POS_W-1:0] prev_below;
    logic [POS_W-1:0] smallest;
    logic [POS_W-1:0] largest;
    logic             is_empty;
    logic             out_of_range;
  } set_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OP_W-1:0] op_i = '0;
  logic [POS_W-1:0] position_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [POS_W-1:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [POS_W-1:0] next_above_o, prev_below_o, smallest_o, largest_o;
  logic is_empty_o, out_of_range_o;

  ordered_bitmap_set_neighbour_find_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .position_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .out_valid_o, .out_stall_i,
    .next_above_o, .prev_below_o, .smallest_o, .largest_o, .is_empty_o,
    .out_of_range_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the set and the size register.
  logic [MAX_POS-1:0] shadow_members;
  logic [POS_W-1:0]   shadow_size;

  set_req_t    pending_reqs[$];
  set_answer_t awaited_answers[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_recv = 1'b0;
  bit          drain_wait = 1'b0;
  int          fail_count = 0;
  int          sent_count = 0;
  int          got_count = 0;
  int          oor_count = 0;
  int          quiet_cycles = 0;
  int          cfg_count = 0;

  // Apply one request to the shadow set and return the expected answer.
  function automatic set_answer_t find_neighbours(set_req_t req);
    set_answer_t a;
    int limit;
    int p;
    a = '0;
    p = req.position;
    limit = (shadow_size < MAX_POS) ? shadow_size : MAX_POS;
    a.out_of_range = (p == 0) || (p > limit);
    if (!a.out_of_range && req.op == obsnf_pkg::OP_INSERT) shadow_members[p-1] = 1'b1;
    if (!a.out_of_range && req.op == obsnf_pkg::OP_REMOVE) shadow_members[p-1] = 1'b0;
    if (!a.out_of_range) begin
      for (int i = p; i < MAX_POS; i++)
        if (shadow_members[i]) begin a.next_above = POS_W'(i + 1); break; end
      for (int i = p - 2; i >= 0; i--)
        if (shadow_members[i]) begin a.prev_below = POS_W'(i + 1); break; end
    end
    for (int i = 0; i < MAX_POS; i++)
      if (shadow_members[i]) begin a.smallest = POS_W'(i + 1); break; end
    for (int i = MAX_POS - 1; i >= 0; i--)
      if (shadow_members[i]) begin a.largest = POS_W'(i + 1); break; end
    a.is_empty = (shadow_members == '0);
    return a;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("result %0d: %s got %0d expected %0d", got_count, field, got, want);
    fail_count++;
  endtask

  // Driver: advance to the next pending item after each transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        awaited_answers.insert(awaited_answers.size(), find_neighbours({op_i, position_i}));
        sent_count++;
      end
      if ((!in_valid_i || !in_stall_o) ) begin
        if (pending_reqs.size() > 0 && !drain_wait &&
            $urandom_range(99) >= send_idle_pct) begin
          set_req_t r;
          r = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          op_i <= r.op;
          position_i <= r.position;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          set_answer_t e;
          e = awaited_answers.pop_front();
          if (next_above_o !== e.next_above)
            report_mismatch("next_above", next_above_o, e.next_above);
          if (prev_below_o !== e.prev_below)
            report_mismatch("prev_below", prev_below_o, e.prev_below);
          if (smallest_o !== e.smallest)
            report_mismatch("smallest", smallest_o, e.smallest);
          if (largest_o !== e.largest)
            report_mismatch("largest", largest_o, e.largest);
          if (is_empty_o !== e.is_empty)
            report_mismatch("is_empty", is_empty_o, e.is_empty);
          if (out_of_range_o !== e.out_of_range)
            report_mismatch("out_of_range", out_of_range_o, e.out_of_range);
          if (e.out_of_range) oor_count++;
        end
        got_count++;
      end
      out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("ordered_bitmap_set_neighbour_find_top: mismatch");
      $finish;
    end
  end

  function automatic set_req_t random_req(int limit);
    set_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.op = (pick < 45) ? obsnf_pkg::OP_INSERT : (pick < 75) ? obsnf_pkg::OP_REMOVE :
           (pick < 95) ? obsnf_pkg::OP_QUERY : obsnf_pkg::OP_SPARE;
    pick = $urandom_range(99);
    if (pick < 85) r.position = POS_W'($urandom_range(limit < 1 ? 1 : limit, 1));
    else if (pick < 92) r.position = POS_W'($urandom_range(2047));
    else r.position = (pick < 96) ? 11'd0 : POS_W'(limit);
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || awaited_answers.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // Write the size register while the block is idle.
  task automatic write_size(logic [POS_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_size = value;
    cfg_count++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos);
    set_req_t r;
    r.op = op;
    r.position = pos;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic queue_random(int count, int limit);
    repeat (count) pending_reqs.insert(pending_reqs.size(), random_req(limit));
  endtask

  initial begin
    logic [POS_W-1:0] sizes[6];
    shadow_members = '0;
    shadow_size = obsnf_pkg::SIZE_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every op code, out of range, redundant updates.
    queue_req(obsnf_pkg::OP_QUERY, 11'd5);
    queue_req(obsnf_pkg::OP_INSERT, 11'd1);
    queue_req(obsnf_pkg::OP_INSERT, 11'd1024);
    queue_req(obsnf_pkg::OP_INSERT, 11'd64);
    queue_req(obsnf_pkg::OP_INSERT, 11'd65);
    queue_req(obsnf_pkg::OP_INSERT, 11'd64);
    queue_req(obsnf_pkg::OP_QUERY, 11'd64);
    queue_req(obsnf_pkg::OP_QUERY, 11'd1);
    queue_req(obsnf_pkg::OP_QUERY, 11'd1024);
    queue_req(obsnf_pkg::OP_INSERT, 11'd0);
    queue_req(obsnf_pkg::OP_INSERT, 11'd1025);
    queue_req(obsnf_pkg::OP_QUERY, 11'd2047);
    queue_req(obsnf_pkg::OP_SPARE, 11'd500);
    queue_req(obsnf_pkg::OP_REMOVE, 11'd300);
    queue_req(obsnf_pkg::OP_REMOVE, 11'd64);
    queue_req(obsnf_pkg::OP_REMOVE, 11'd1);
    queue_req(obsnf_pkg::OP_QUERY, 11'd1365);
    queue_req(obsnf_pkg::OP_REMOVE, 11'd1024);
    queue_req(obsnf_pkg::OP_REMOVE, 11'd65);
    queue_req(obsnf_pkg::OP_QUERY, 11'd2);
    wait_drained();

    // Limit lowered below existing members, then zero, then raised again.
    queue_req(obsnf_pkg::OP_INSERT, 11'd900);
    wait_drained();
    write_size(11'd10);
    queue_req(obsnf_pkg::OP_QUERY, 11'd10);
    queue_req(obsnf_pkg::OP_INSERT, 11'd11);
    wait_drained();
    write_size(11'd0);
    queue_req(obsnf_pkg::OP_INSERT, 11'd1);
    wait_drained();
    write_size(11'd2047);
    queue_req(obsnf_pkg::OP_INSERT, 11'd1024);
    queue_req(obsnf_pkg::OP_REMOVE, 11'd900);
    wait_drained();

    // Random phases across idle profiles and sizes.
    sizes = '{11'd1024, 11'd1, 11'd100, 11'd2047, 11'd64, 11'd1024};
    for (int ph = 0; ph < 6; ph++) begin
      write_size(sizes[ph]);
      send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 63 : 0;
      recv_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 35 : 0;
      queue_random(270, sizes[ph] > MAX_POS ? MAX_POS : sizes[ph]);
      if (ph == 4) begin
        // Hold off the receiver so the block backs up onto its input.
        fork
          begin
            hold_recv <= 1'b1;
            repeat (300) @(posedge clk_i);
            hold_recv <= 1'b0;
          end
        join_none
      end
      if (ph == 2) begin
        // Pause the sender until every expected result has arrived.
        while (pending_reqs.size() > 135) @(posedge clk_i);
        drain_wait = 1'b1;
        while (in_valid_i || awaited_answers.size() > 0) @(posedge clk_i);
        drain_wait = 1'b0;
      end
      wait_drained();
    end

    $display("sent %0d items, checked %0d results (%0d out of range), %0d size writes",
             sent_count, got_count, oor_count, cfg_count);
    if (fail_count == 0) begin
      $display("ordered_bitmap_set_neighbour_find_top: match");
    end else begin
      $display("ordered_bitmap_set_neighbour_find_top: mismatch");
    end
    $finish;
  end
endmodule
